[rtl/assert_macros.svh]
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define ASSERT_AR(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_AR(lbl, clk, rst_n, prop, msg)
`define ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

[rtl/mtp_pkg.sv]
package mtp_pkg;

  localparam int unsigned StateWords = 624;
  localparam int unsigned TwistOffset = 397;
  localparam int unsigned IdxW = 10;
  localparam int unsigned WordW = 32;

  localparam logic [IdxW-1:0] LastIdx = IdxW'(StateWords - 1);
  localparam logic [IdxW-1:0] FarWrap = IdxW'(StateWords - TwistOffset);
  localparam logic [IdxW-1:0] FarAdd = IdxW'(TwistOffset);

  localparam logic [WordW-1:0] TwistMatrix = 32'h9908_b0df;
  localparam logic [WordW-1:0] InitMult = 32'd1812433253;
  localparam logic [WordW-1:0] SeedReset = 32'd5489;
  localparam logic [WordW-1:0] TemperB = 32'h9d2c_5680;
  localparam logic [WordW-1:0] TemperC = 32'hefc6_0000;

  typedef logic [IdxW-1:0] idx_t;
  typedef logic [WordW-1:0] word_t;

  typedef struct packed {
    logic  we;
    idx_t  waddr;
    word_t wdata;
    idx_t  raddr_a;
    idx_t  raddr_b;
  } mem_req_t;

  function automatic idx_t succ_idx(input idx_t pos);
    return (pos == LastIdx) ? '0 : idx_t'(pos + idx_t'(1));
  endfunction

  function automatic idx_t far_idx(input idx_t pos);
    return (pos < FarWrap) ? idx_t'(pos + FarAdd) : idx_t'(pos - FarWrap);
  endfunction

  function automatic word_t seed_next(input word_t prev, input idx_t idx);
    word_t mixed;
    word_t prod;
    mixed = prev ^ (prev >> 30);
    prod = mixed * InitMult;
    return prod + {{(WordW-IdxW){1'b0}}, idx};
  endfunction

  function automatic word_t twist_word(input word_t cur, input word_t nxt, input word_t far);
    word_t y;
    y = {cur[WordW-1], nxt[WordW-2:0]};
    return far ^ (y >> 1) ^ (y[0] ? TwistMatrix : '0);
  endfunction

  function automatic word_t temper(input word_t w);
    word_t y;
    y = w ^ (w >> 11);
    y = y ^ ((y << 7) & TemperB);
    y = y ^ ((y << 15) & TemperC);
    y = y ^ (y >> 18);
    return y;
  endfunction

endpackage

[rtl/mtp_state_mem.sv]
module mtp_state_mem import mtp_pkg::*; (
  input  logic     clk_i,
  input  mem_req_t req_i,
  output word_t    rdata_a_o,
  output word_t    rdata_b_o
);

  word_t mem [StateWords];
  word_t rdata_a_q;
  word_t rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    rdata_a_q <= mem[req_i.raddr_a];
    rdata_b_q <= mem[req_i.raddr_b];
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

[rtl/mtp_ctrl.sv]
`include "assert_macros.svh"

module mtp_ctrl import mtp_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  logic     draw_i,
  input  logic     cfg_we_i,
  input  word_t    seed_i,
  output logic     idle_o,
  output logic     res_valid_o,
  input  logic     res_ready_i,
  output word_t    res_word_o,
  output mem_req_t mem_req_o,
  input  word_t    rdata_a_i,
  input  word_t    rdata_b_i
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SEED  = 4'b0010,
    ST_ISSUE = 4'b0100,
    ST_CALC  = 4'b1000
  } state_e;

  state_e state_q, state_d;
  idx_t   pos_q, pos_d;
  idx_t   cnt_q, cnt_d;
  logic   seeded_q, seeded_d;
  word_t  prev_q, prev_d;
  word_t  cur_q, cur_d;
  word_t  twisted;
  word_t  seed_word;

  assign twisted = twist_word(cur_q, rdata_a_i, rdata_b_i);
  assign seed_word = seed_next(prev_q, cnt_q);

  always_comb begin
    state_d = state_q;
    pos_d = pos_q;
    cnt_d = cnt_q;
    seeded_d = seeded_q;
    prev_d = prev_q;
    cur_d = cur_q;
    in_ready_o = 1'b0;
    res_valid_o = 1'b0;
    mem_req_o.we = 1'b0;
    mem_req_o.waddr = pos_q;
    mem_req_o.wdata = twisted;
    mem_req_o.raddr_a = succ_idx(pos_q);
    mem_req_o.raddr_b = far_idx(pos_q);
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = !cfg_we_i;
        if (cfg_we_i) begin
          seeded_d = 1'b0;
        end else if (in_valid_i && draw_i) begin
          if (seeded_q) begin
            state_d = ST_ISSUE;
          end else begin
            mem_req_o.we = 1'b1;
            mem_req_o.waddr = '0;
            mem_req_o.wdata = seed_i;
            prev_d = seed_i;
            cur_d = seed_i;
            cnt_d = idx_t'(1);
            pos_d = '0;
            state_d = ST_SEED;
          end
        end
      end
      ST_SEED: begin
        mem_req_o.we = 1'b1;
        mem_req_o.waddr = cnt_q;
        mem_req_o.wdata = seed_word;
        prev_d = seed_word;
        cnt_d = idx_t'(cnt_q + idx_t'(1));
        if (cnt_q == LastIdx) begin
          seeded_d = 1'b1;
          state_d = ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        state_d = ST_CALC;
      end
      ST_CALC: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          mem_req_o.we = 1'b1;
          cur_d = rdata_a_i;
          pos_d = succ_idx(pos_q);
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign res_word_o = temper(twisted);
  assign idle_o = (state_q == ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      pos_q <= '0;
      cnt_q <= '0;
      seeded_q <= 1'b0;
    end else begin
      state_q <= state_d;
      pos_q <= pos_d;
      cnt_q <= cnt_d;
      seeded_q <= seeded_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prev_q <= prev_d;
    cur_q <= cur_d;
  end

  `ASSERT_AR(issue_needs_seed_a, clk_i, rst_ni, (state_q == ST_ISSUE) |-> seeded_q, "twist started on unseeded state")
  `ASSERT_AR(no_write_on_issue_a, clk_i, rst_ni, (state_q == ST_ISSUE) |-> !mem_req_o.we, "state written while reads are in flight")
  `ASSERT_AR(pos_advance_a, clk_i, rst_ni, (state_q == ST_CALC && res_ready_i && pos_q != LastIdx) |=> (pos_q == idx_t'($past(pos_q) + idx_t'(1))), "read position did not advance by one")
  `ASSERT_AR(pos_range_a, clk_i, rst_ni, pos_q <= LastIdx, "read position out of range")

endmodule

[rtl/mersenne_twister_prng.sv]
// Channel | Handshake              | Payload
// in      | in_valid_i, in_ready_o  | draw_i
// out     | out_valid_o, out_ready_i| value_o
// cfg     | cfg_valid_i, cfg_ready_o| seed_i
//
// A draw passes from acceptance to a result in the output register in order through
// the accept step, a state memory read step and a twist step.
// The first draw after reset or after a seed write first runs the seeding pass.
// An item with draw low is accepted and produces no result.
// A full output register stalls the twist cycle; the seed is taken only while idle.
// A seed write holds off an input item offered in the same cycle.
`include "assert_macros.svh"

module mersenne_twister_prng import mtp_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  logic  draw_i,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  output word_t value_o,
  input  logic  cfg_valid_i,
  output logic  cfg_ready_o,
  input  word_t seed_i
);

  word_t    seed_q;
  logic     out_valid_q, out_valid_d;
  word_t    value_q;
  logic     idle;
  logic     cfg_we;
  logic     res_valid;
  logic     res_ready;
  word_t    res_word;
  mem_req_t mem_req;
  word_t    rdata_a;
  word_t    rdata_b;

  assign cfg_ready_o = idle;
  assign cfg_we = cfg_valid_i && idle;
  assign res_ready = !out_valid_q || out_ready_i;

  mtp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .draw_i      (draw_i),
    .cfg_we_i    (cfg_we),
    .seed_i      (seed_q),
    .idle_o      (idle),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_word_o  (res_word),
    .mem_req_o   (mem_req),
    .rdata_a_i   (rdata_a),
    .rdata_b_i   (rdata_b)
  );

  mtp_state_mem u_mem (
    .clk_i     (clk_i),
    .req_i     (mem_req),
    .rdata_a_o (rdata_a),
    .rdata_b_o (rdata_b)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (res_valid && res_ready) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q <= SeedReset;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (cfg_we) begin
        seed_q <= seed_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      value_q <= res_word;
    end
  end

  assign out_valid_o = out_valid_q;
  assign value_o = value_q;

  `ASSERT_AR(no_overwrite_a, clk_i, rst_ni, (out_valid_q && !out_ready_i) |-> !(res_valid && res_ready), "pending result overwritten")
  `ASSERT_AR(seed_write_idle_a, clk_i, rst_ni, cfg_we |-> !res_valid, "seed written while a draw is in progress")
  `ASSERT_ALWAYS(reset_clear_a, clk_i, !rst_ni |=> !out_valid_q, "output valid set during reset")

endmodule
